// ----- src/hpr_pkg.sv -----
// Shared types, codes and saturation helpers for the heightfield ray marcher.
`timescale 1ns / 1ps
`default_nettype none

package hpr_pkg;

    // Operation codes carried in the op field of an input beat.
    localparam logic [1:0] OP_LOAD_PIXEL = 2'd0;
    localparam logic [1:0] OP_LOAD_TABLE = 2'd1;
    localparam logic [1:0] OP_CAST_RAY   = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_PANEL_ORIGIN  = 3'd0;
    localparam logic [2:0] CFG_X_STEP_VECTOR = 3'd1;
    localparam logic [2:0] CFG_Y_STEP_VECTOR = 3'd2;
    localparam logic [2:0] CFG_HEIGHT_AXIS   = 3'd3;
    localparam logic [2:0] CFG_USED_WIDTH    = 3'd4;
    localparam logic [2:0] CFG_USED_HEIGHT   = 3'd5;

    localparam logic [8:0] USED_SIZE_RESET = 9'd256;

    // Margin above the top code height, 0.001 in Q15.16.
    localparam logic signed [33:0] SLAB_MARGIN = 34'sd66;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [35:0] S32_MAX36 = 36'sd2147483647;
    localparam logic signed [35:0] S32_MIN36 = -36'sd2147483648;

    // Kind of work that the front hands to the back.
    typedef enum logic [1:0] {
        K_PIXEL,
        K_TABLE,
        K_RAY
    } t_kind;

    typedef struct packed {
        logic [1:0]         op;
        logic [7:0]         pixel_x;
        logic [7:0]         pixel_y;
        logic [7:0]         depth_code;
        logic [7:0]         table_index;
        logic signed [31:0] table_value;
        logic signed [31:0] ray_px;
        logic signed [31:0] ray_py;
        logic signed [31:0] ray_pz;
        logic signed [31:0] ray_vx;
        logic signed [31:0] ray_vy;
        logic signed [31:0] ray_vz;
    } t_in_item;

    typedef struct packed {
        logic       hit;
        logic [7:0] hit_x;
        logic [7:0] hit_y;
    } t_out_item;

    typedef struct packed {
        t_kind    kind;
        t_in_item item;
    } t_q_item;

    typedef struct packed {
        logic [62:0] panel_origin;
        logic [62:0] x_step_vector;
        logic [62:0] y_step_vector;
        logic [62:0] height_axis;
        logic [8:0]  used_width;
        logic [8:0]  used_height;
    } t_cfg;

    // Apply a sign to a magnitude and saturate to 32 bits.
    function automatic logic signed [31:0] f_mag_sat(input logic [47:0] m, input logic neg);
        logic signed [31:0] r;
        if (neg) begin
            if (m >= 48'h0000_8000_0000) r = S32_MIN;
            else r = signed'(32'd0 - m[31:0]);
        end else begin
            if (m > 48'h0000_7FFF_FFFF) r = S32_MAX;
            else r = signed'(m[31:0]);
        end
        return r;
    endfunction

    // Saturate a widened signed sum back to 32 bits.
    function automatic logic signed [31:0] f_sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX36) r = S32_MAX;
        else if (v < S32_MIN36) r = S32_MIN;
        else r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/hpr_front.sv -----
// Input side: accepts beats, classifies them and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none

module hpr_front
    import hpr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_in_item i_in_data,
    output logic          o_in_stall,
    output logic          o_q_valid,
    output t_q_item       o_q_item,
    input  wire logic     i_q_pop
);

    t_q_item    r_buf [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic [1:0] n_count;

    logic  accept;
    logic  push;
    t_kind kind;

    // Classify the incoming beat; an unknown op is taken and dropped.
    always_comb begin
        kind = K_RAY;
        push = 1'b0;
        case (i_in_data.op)
            OP_LOAD_PIXEL: begin
                kind = K_PIXEL;
                push = accept;
            end
            OP_LOAD_TABLE: begin
                kind = K_TABLE;
                push = accept;
            end
            OP_CAST_RAY: begin
                kind = K_RAY;
                push = accept;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    assign o_in_stall = (r_count == 2'd2);
    assign accept     = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_item   = r_buf[r_rd];

    always_comb begin
        n_count = r_count;
        if (push && !i_q_pop) n_count = r_count + 2'd1;
        else if (!push && i_q_pop) n_count = r_count - 2'd1;
    end

    // Two-entry queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) r_wr <= !r_wr;
            if (i_q_pop) r_rd <= !r_rd;
            r_count <= n_count;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr].kind <= kind;
            r_buf[r_wr].item <= i_in_data;
        end
    end

endmodule

`default_nettype wire

// ----- src/hpr_div.sv -----
// Iterative signed Q16 divider with saturation, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module hpr_div
    import hpr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [63:0] i_num,
    input  wire logic signed [63:0] i_den,
    output logic                    o_done,
    output logic signed [31:0]      o_quot
);

    typedef enum logic [1:0] {
        D_IDLE,
        D_PREP,
        D_ITER,
        D_FIN
    } t_dstate;

    t_dstate            r_state;
    logic [63:0]        r_un;
    logic [63:0]        r_ud;
    logic               r_neg;
    logic               r_dz;
    logic               r_npos;
    logic               r_nneg;
    logic [63:0]        r_rem;
    logic [31:0]        r_sh;
    logic [31:0]        r_q;
    logic [4:0]         r_cnt;
    logic               r_done;
    logic signed [31:0] r_quot;

    logic [63:0] num_mag;
    logic [63:0] den_mag;
    logic [64:0] rem_try;
    logic [64:0] rem_sub;
    logic        rem_ge;
    logic        ovf;

    assign num_mag = i_num[63] ? 64'd0 - unsigned'(i_num) : unsigned'(i_num);
    assign den_mag = i_den[63] ? 64'd0 - unsigned'(i_den) : unsigned'(i_den);
    assign rem_try = {r_rem, r_sh[31]};
    assign rem_ge  = (rem_try >= {1'b0, r_ud});
    assign rem_sub = rem_try - {1'b0, r_ud};
    // The quotient reaches 2^32 exactly when the numerator is at least den * 2^16.
    assign ovf     = ({16'd0, r_un} >= {r_ud, 16'd0});

    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_un    <= num_mag;
                        r_ud    <= den_mag;
                        r_neg   <= i_num[63] != i_den[63];
                        r_dz    <= (i_den == 64'sd0);
                        r_npos  <= !i_num[63] && (i_num != 64'sd0);
                        r_nneg  <= i_num[63];
                        r_state <= D_PREP;
                    end
                end
                D_PREP: begin
                    // Zero divisor and overflow settle here; otherwise start the long division.
                    if (r_dz) begin
                        r_quot  <= r_npos ? S32_MAX : (r_nneg ? S32_MIN : 32'sd0);
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end else if (ovf) begin
                        r_quot  <= f_mag_sat(48'h0001_0000_0000, r_neg);
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end else begin
                        r_rem   <= {16'd0, r_un[63:16]};
                        r_sh    <= {r_un[15:0], 16'd0};
                        r_q     <= 32'd0;
                        r_cnt   <= 5'd0;
                        r_state <= D_ITER;
                    end
                end
                D_ITER: begin
                    r_rem   <= rem_ge ? rem_sub[63:0] : rem_try[63:0];
                    r_q     <= {r_q[30:0], rem_ge};
                    r_sh    <= {r_sh[30:0], 1'b0};
                    r_cnt   <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) r_state <= D_FIN;
                end
                D_FIN: begin
                    r_quot  <= f_mag_sat(48'(r_q), r_neg);
                    r_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- src/hpr_back.sv -----
// Back end: applies loads, sets a ray up and walks pixel columns until it stops.
`timescale 1ns / 1ps
`default_nettype none

module hpr_back
    import hpr_pkg::*;
#(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 256,
    parameter int DEPTH_CODES = 256
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cfg    i_cfg,
    input  wire logic    i_q_valid,
    input  wire t_q_item i_q_item,
    output logic         o_q_pop,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_out_item    o_out_data
);

    localparam int PAW      = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int TAW      = $clog2(DEPTH_CODES);
    localparam int CXW      = $clog2(MAX_WIDTH) + 2;
    localparam int CYW      = $clog2(MAX_HEIGHT) + 2;
    localparam int TOP_CODE = DEPTH_CODES - 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DOT,
        S_DGO,
        S_DWAIT,
        S_CHK0,
        S_CMULX,
        S_CMULY,
        S_TOP,
        S_PIX,
        S_HGT,
        S_TEST,
        S_MUL,
        S_ZUPD,
        S_OUT
    } t_state;

    t_state r_state;

    // Configuration vectors split into signed components.
    logic signed [20:0] org [3];
    logic signed [20:0] xax [3];
    logic signed [20:0] yax [3];
    logic signed [20:0] zax [3];
    logic [8:0]         w_lim;
    logic [8:0]         h_lim;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            org[k] = signed'(i_cfg.panel_origin[21*k +: 21]);
            xax[k] = signed'(i_cfg.x_step_vector[21*k +: 21]);
            yax[k] = signed'(i_cfg.y_step_vector[21*k +: 21]);
            zax[k] = signed'(i_cfg.height_axis[21*k +: 21]);
        end
        w_lim = (int'(i_cfg.used_width) > MAX_WIDTH) ? 9'(MAX_WIDTH) : i_cfg.used_width;
        h_lim = (int'(i_cfg.used_height) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : i_cfg.used_height;
    end

    // Ray registers and setup results.
    logic signed [32:0] r_rel [3];
    logic signed [31:0] r_v [3];
    logic signed [55:0] r_dot [9];
    logic [3:0]         r_dj;
    logic [1:0]         r_dk;
    logic [2:0]         r_dsel;
    logic [58:0]        r_cxaa;
    logic [58:0]        r_cyaa;
    logic signed [31:0] r_fx;
    logic signed [31:0] r_fy;
    logic signed [31:0] r_lox;
    logic signed [31:0] r_hix;
    logic signed [31:0] r_loy;
    logic signed [31:0] r_hiy;
    logic signed [31:0] r_z;
    logic signed [31:0] r_zp;
    logic signed [33:0] r_maxz;

    // March registers.
    logic signed [31:0]    r_nx;
    logic signed [31:0]    r_ny;
    logic [32:0]           r_incx;
    logic [32:0]           r_incy;
    logic                  r_sxneg;
    logic                  r_syneg;
    logic signed [31:0]    r_t;
    logic signed [31:0]    r_nt;
    logic signed [32:0]    r_diff;
    logic [63:0]           r_prod;
    logic                  r_mneg;
    logic signed [31:0]    r_h;
    logic signed [CXW-1:0] r_cx;
    logic signed [CYW-1:0] r_cy;
    logic [7:0]            r_code;
    t_out_item             r_res;
    logic                  r_out_valid;
    t_out_item             r_out_data;

    // Memories.
    logic [7:0]         r_pix_mem [MAX_WIDTH * MAX_HEIGHT];
    logic [7:0]         r_pix_q;
    logic signed [31:0] r_tab_mem [DEPTH_CODES];
    logic signed [31:0] r_tab_q;

    logic [PAW-1:0] pix_wr_addr;
    logic [PAW-1:0] pix_rd_addr;
    logic           pix_we;
    logic [TAW-1:0] tab_wr_addr;
    logic [TAW-1:0] tab_rd_addr;
    logic           tab_we;
    t_in_item       item;

    assign item    = i_q_item.item;
    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    // Load decode: out-of-range loads are dropped.
    always_comb begin
        pix_wr_addr = PAW'(int'(item.pixel_y) * MAX_WIDTH + int'(item.pixel_x));
        pix_we      = o_q_pop && (i_q_item.kind == K_PIXEL)
                      && (int'(item.pixel_x) < MAX_WIDTH) && (int'(item.pixel_y) < MAX_HEIGHT);
        tab_wr_addr = TAW'(item.table_index);
        tab_we      = o_q_pop && (i_q_item.kind == K_TABLE)
                      && (int'(item.table_index) < DEPTH_CODES);
        pix_rd_addr = PAW'(int'(r_cy[CYW-2:0]) * MAX_WIDTH + int'(r_cx[CXW-2:0]));
        // The top entry is read for the slab limit; codes past the table use it too.
        if (r_state == S_HGT && int'(r_pix_q) <= TOP_CODE) tab_rd_addr = TAW'(r_pix_q);
        else tab_rd_addr = TAW'(TOP_CODE);
    end

    always_ff @(posedge i_clk) begin
        if (pix_we) r_pix_mem[pix_wr_addr] <= item.depth_code;
        r_pix_q <= r_pix_mem[pix_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (tab_we) r_tab_mem[tab_wr_addr] <= item.table_value;
        r_tab_q <= r_tab_mem[tab_rd_addr];
    end

    // Shared multiplier for the dot products, one term a cycle.
    logic signed [20:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [53:0] mul_p;

    always_comb begin
        mul_a = xax[r_dk];
        mul_b = 33'(xax[r_dk]);
        case (r_dj)
            4'd0: begin mul_a = xax[r_dk]; mul_b = 33'(xax[r_dk]); end
            4'd1: begin mul_a = xax[r_dk]; mul_b = r_rel[r_dk]; end
            4'd2: begin mul_a = xax[r_dk]; mul_b = 33'(r_v[r_dk]); end
            4'd3: begin mul_a = yax[r_dk]; mul_b = 33'(yax[r_dk]); end
            4'd4: begin mul_a = yax[r_dk]; mul_b = r_rel[r_dk]; end
            4'd5: begin mul_a = yax[r_dk]; mul_b = 33'(r_v[r_dk]); end
            4'd6: begin mul_a = zax[r_dk]; mul_b = 33'(zax[r_dk]); end
            4'd7: begin mul_a = zax[r_dk]; mul_b = r_rel[r_dk]; end
            4'd8: begin mul_a = zax[r_dk]; mul_b = 33'(r_v[r_dk]); end
            default: begin mul_a = zax[r_dk]; mul_b = 33'(r_v[r_dk]); end
        endcase
    end

    assign mul_p = 54'(mul_a) * 54'(mul_b);

    // Cell index times axis length squared; the squared length is non-negative and small.
    logic [14:0] cm_cell;
    logic [43:0] cm_aa;
    logic [58:0] cm_p;

    assign cm_cell = (r_state == S_CMULX) ? r_fx[30:16] : r_fy[30:16];
    assign cm_aa   = (r_state == S_CMULX) ? r_dot[0][43:0] : r_dot[3][43:0];
    assign cm_p    = 59'(cm_cell) * 59'(cm_aa);

    // Divider operand selection.
    logic signed [63:0] div_num;
    logic signed [63:0] div_den;
    logic               div_start;
    logic               div_done;
    logic signed [31:0] div_quot;

    always_comb begin
        div_num = 64'(r_dot[1]);
        div_den = 64'(r_dot[0]);
        case (r_dsel)
            3'd0: begin div_num = 64'(r_dot[1]); div_den = 64'(r_dot[0]); end
            3'd1: begin div_num = 64'(r_dot[4]); div_den = 64'(r_dot[3]); end
            3'd2: begin
                div_num = signed'(64'(r_cxaa)) - 64'(r_dot[1]);
                div_den = 64'(r_dot[2]);
            end
            3'd3: begin
                div_num = signed'(64'(r_cxaa)) + 64'(r_dot[0]) - 64'(r_dot[1]);
                div_den = 64'(r_dot[2]);
            end
            3'd4: begin
                div_num = signed'(64'(r_cyaa)) - 64'(r_dot[4]);
                div_den = 64'(r_dot[5]);
            end
            3'd5: begin
                div_num = signed'(64'(r_cyaa)) + 64'(r_dot[3]) - 64'(r_dot[4]);
                div_den = 64'(r_dot[5]);
            end
            3'd6: begin div_num = 64'(r_dot[7]); div_den = 64'(r_dot[6]); end
            3'd7: begin div_num = 64'(r_dot[8]); div_den = 64'(r_dot[6]); end
            default: begin div_num = 64'(r_dot[8]); div_den = 64'(r_dot[6]); end
        endcase
    end

    assign div_start = (r_state == S_DGO);

    hpr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Step arithmetic for one column boundary.
    logic signed [31:0]    nt;
    logic [31:0]           ua;
    logic [32:0]           dmag;
    logic [31:0]           ub;
    logic signed [31:0]    term;
    logic signed [31:0]    znew;
    logic                  go_x;
    logic signed [CXW-1:0] n_cx;
    logic signed [CYW-1:0] n_cy;
    logic signed [31:0]    n_nx;
    logic signed [31:0]    n_ny;
    logic                  n_inside;
    logic                  z_below_top;
    logic                  cont;

    always_comb begin
        nt    = (r_nx < r_ny) ? r_nx : r_ny;
        ua    = r_zp[31] ? 32'd0 - unsigned'(r_zp) : unsigned'(r_zp);
        dmag  = r_diff[32] ? 33'd0 - unsigned'(r_diff) : unsigned'(r_diff);
        ub    = dmag[32] ? 32'hFFFF_FFFF : dmag[31:0];
        term  = f_mag_sat(r_prod[63:16], r_mneg);
        znew  = f_sat32(36'(r_z) + 36'(term));
        go_x  = (r_nx < r_ny);
        n_cx  = r_cx;
        n_cy  = r_cy;
        n_nx  = r_nx;
        n_ny  = r_ny;
        if (go_x) begin
            n_nx = f_sat32(36'(r_nx) + signed'(36'(r_incx)));
            n_cx = r_sxneg ? r_cx - CXW'(1) : r_cx + CXW'(1);
        end else begin
            n_ny = f_sat32(36'(r_ny) + signed'(36'(r_incy)));
            n_cy = r_syneg ? r_cy - CYW'(1) : r_cy + CYW'(1);
        end
        n_inside = !n_cx[CXW-1] && !n_cy[CYW-1]
                   && (16'(n_cx[CXW-2:0]) < 16'(w_lim))
                   && (16'(n_cy[CYW-2:0]) < 16'(h_lim));
        z_below_top = (34'(r_z) < r_maxz);
        cont = z_below_top && (r_z > r_tab_q) && ((r_code != 8'd0) || (r_z > 32'sd0));
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Sequencer: setup, march and result hand-off.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // The output register loads a new result or empties when its beat is taken.
            if (r_state == S_OUT && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop && i_q_item.kind == K_RAY) begin
                        r_rel[0] <= 33'(item.ray_px) - 33'(org[0]);
                        r_rel[1] <= 33'(item.ray_py) - 33'(org[1]);
                        r_rel[2] <= 33'(item.ray_pz) - 33'(org[2]);
                        r_v[0]   <= item.ray_vx;
                        r_v[1]   <= item.ray_vy;
                        r_v[2]   <= item.ray_vz;
                        r_dj     <= 4'd0;
                        r_dk     <= 2'd0;
                        r_state  <= S_DOT;
                    end
                end
                S_DOT: begin
                    r_dot[r_dj] <= ((r_dk == 2'd0) ? 56'sd0 : r_dot[r_dj]) + 56'(mul_p);
                    if (r_dk == 2'd2) begin
                        r_dk <= 2'd0;
                        r_dj <= r_dj + 4'd1;
                        if (r_dj == 4'd8) begin
                            r_dsel  <= 3'd0;
                            r_state <= S_DGO;
                        end
                    end else begin
                        r_dk <= r_dk + 2'd1;
                    end
                end
                S_DGO: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (div_done) begin
                        case (r_dsel)
                            3'd0: r_fx  <= div_quot;
                            3'd1: r_fy  <= div_quot;
                            3'd2: r_lox <= div_quot;
                            3'd3: r_hix <= div_quot;
                            3'd4: r_loy <= div_quot;
                            3'd5: r_hiy <= div_quot;
                            3'd6: r_z   <= div_quot;
                            3'd7: r_zp  <= div_quot;
                            default: r_zp <= div_quot;
                        endcase
                        r_dsel <= r_dsel + 3'd1;
                        if (r_dsel == 3'd1) r_state <= S_CHK0;
                        else if (r_dsel == 3'd7) r_state <= S_TOP;
                        else r_state <= S_DGO;
                    end
                end
                S_CHK0: begin
                    // A start outside the used panel misses at once.
                    if (r_fx[31] || r_fy[31] || (r_fx[30:16] >= 15'(w_lim))
                            || (r_fy[30:16] >= 15'(h_lim))) begin
                        r_res   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_cx    <= CXW'(r_fx[30:16]);
                        r_cy    <= CYW'(r_fy[30:16]);
                        r_state <= S_CMULX;
                    end
                end
                S_CMULX: begin
                    r_cxaa  <= cm_p;
                    r_state <= S_CMULY;
                end
                S_CMULY: begin
                    r_cyaa  <= cm_p;
                    r_state <= S_DGO;
                end
                S_TOP: begin
                    // Slab limit and the first boundary on each axis.
                    r_maxz <= 34'(r_tab_q) + SLAB_MARGIN;
                    r_t    <= 32'sd0;
                    if (r_hix > r_lox) begin
                        r_sxneg <= 1'b0;
                        r_nx    <= r_hix;
                        r_incx  <= unsigned'(33'(r_hix) - 33'(r_lox));
                    end else begin
                        r_sxneg <= 1'b1;
                        r_nx    <= r_lox;
                        r_incx  <= unsigned'(33'(r_lox) - 33'(r_hix));
                    end
                    if (r_hiy > r_loy) begin
                        r_syneg <= 1'b0;
                        r_ny    <= r_hiy;
                        r_incy  <= unsigned'(33'(r_hiy) - 33'(r_loy));
                    end else begin
                        r_syneg <= 1'b1;
                        r_ny    <= r_loy;
                        r_incy  <= unsigned'(33'(r_loy) - 33'(r_hiy));
                    end
                    r_state <= S_PIX;
                end
                S_PIX: begin
                    r_state <= S_HGT;
                end
                S_HGT: begin
                    r_code  <= r_pix_q;
                    r_state <= S_TEST;
                end
                S_TEST: begin
                    if (!cont) begin
                        r_res.hit   <= z_below_top && (r_code != 8'd0);
                        r_res.hit_x <= (z_below_top && r_code != 8'd0) ?
                                       8'(r_cx[CXW-2:0]) : 8'd0;
                        r_res.hit_y <= (z_below_top && r_code != 8'd0) ?
                                       8'(r_cy[CYW-2:0]) : 8'd0;
                        r_state     <= S_OUT;
                    end else begin
                        r_h     <= r_tab_q;
                        r_nt    <= nt;
                        r_diff  <= 33'(nt) - 33'(r_t);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= 64'(ua) * 64'(ub);
                    r_mneg  <= r_zp[31] != r_diff[32];
                    r_state <= S_ZUPD;
                end
                S_ZUPD: begin
                    r_z <= znew;
                    if (znew <= r_h) begin
                        // The ray dropped into the current column.
                        r_res.hit   <= (34'(znew) < r_maxz) && (r_code != 8'd0);
                        r_res.hit_x <= ((34'(znew) < r_maxz) && r_code != 8'd0) ?
                                       8'(r_cx[CXW-2:0]) : 8'd0;
                        r_res.hit_y <= ((34'(znew) < r_maxz) && r_code != 8'd0) ?
                                       8'(r_cy[CYW-2:0]) : 8'd0;
                        r_state     <= S_OUT;
                    end else begin
                        r_t  <= r_nt;
                        r_cx <= n_cx;
                        r_cy <= n_cy;
                        r_nx <= n_nx;
                        r_ny <= n_ny;
                        if (n_inside) begin
                            r_state <= S_PIX;
                        end else begin
                            r_res   <= '0;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_data  <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- src/heightfield_pixel_ray_march.sv -----
// Top level of the heightfield ray marcher: configuration registers, front and back.
// Usage:
// The input channel (i_in_valid, o_in_stall, i_in_data) takes one beat per cycle
// while o_in_stall is low, into a two-entry queue. Op 0 loads a pixel depth code,
// op 1 loads a height table entry, op 2 casts a ray, op 3 is taken and ignored.
// Loads leave the queue at one per cycle while the back end is idle and produce
// no result. Each ray produces one result beat on (o_out_valid, i_out_stall,
// o_out_data). A ray first forms its dot products on one shared multiplier, then
// runs eight divisions on the shared serial divider, then for each column boundary
// crossed does a pixel read, a table read, a test, a multiply and a height update;
// a walk crosses at most used_width plus used_height columns.
// A ray that starts outside the panel ends after the first two divisions.
// The result sits in an output register; while the receiver stalls, the back end
// keeps applying loads and may finish the next ray up to that register.
// Configuration (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data) is always
// ready and must only be written while no ray is in flight.
// Reset clears the queue, the control state and the configuration registers
// (vectors to zero, used sizes to 256); the pixel and height memories are not
// cleared and must be loaded before use.
`timescale 1ns / 1ps
`default_nettype none

module heightfield_pixel_ray_march
    import hpr_pkg::*;
#(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 256,
    parameter int DEPTH_CODES = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_data,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [62:0] i_cfg_data
);

    t_cfg    r_cfg;
    logic    q_valid;
    t_q_item q_item;
    logic    q_pop;

    assign o_cfg_ready = 1'b1;

    // Configuration register file; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.panel_origin  <= '0;
            r_cfg.x_step_vector <= '0;
            r_cfg.y_step_vector <= '0;
            r_cfg.height_axis   <= '0;
            r_cfg.used_width    <= USED_SIZE_RESET;
            r_cfg.used_height   <= USED_SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PANEL_ORIGIN:  r_cfg.panel_origin  <= i_cfg_data;
                CFG_X_STEP_VECTOR: r_cfg.x_step_vector <= i_cfg_data;
                CFG_Y_STEP_VECTOR: r_cfg.y_step_vector <= i_cfg_data;
                CFG_HEIGHT_AXIS:   r_cfg.height_axis   <= i_cfg_data;
                CFG_USED_WIDTH:    r_cfg.used_width    <= i_cfg_data[8:0];
                CFG_USED_HEIGHT:   r_cfg.used_height   <= i_cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    hpr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    hpr_back #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .DEPTH_CODES (DEPTH_CODES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ----- sim/heightfield_ray_checker.sv -----
// Checker that predicts every ray result of the heightfield ray marcher and compares it.
`timescale 1ns / 1ps

module heightfield_ray_checker
    import hpr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_item    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_item   i_out_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [62:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_rays_pending,
    output int          o_hits_seen
);

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;
    localparam int TOP_CODE = 255;
    localparam int PANEL_SPAN = 256;

    // World vector in exact integer form.
    typedef struct packed {
        longint xc;
        longint yc;
        longint zc;
    } wvec_t;

    wvec_t       vec_reg [4];
    int unsigned width_reg;
    int unsigned height_reg;
    logic [7:0]  depth_mem [65536];
    longint      height_mem [256];
    t_out_item   hit_expect_q [$];

    function automatic longint clamp32(longint v);
        return v > Q_MAX ? Q_MAX : (v < Q_MIN ? Q_MIN : v);
    endfunction

    function automatic longint unsigned abs64(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic longint apply_sign(longint unsigned m, bit neg);
        if (neg) begin
            return (m >= 64'h8000_0000) ? Q_MIN : -longint'(m);
        end
        return (m > 64'h7FFF_FFFF) ? Q_MAX : longint'(m);
    endfunction

    // Signed num / den in Q15.16, truncated toward zero and saturated.
    function automatic longint q16_quotient(longint num, longint den);
        longint unsigned un, ud, q, r;
        bit neg;
        if (den == 0) begin
            return num > 0 ? Q_MAX : (num < 0 ? Q_MIN : 0);
        end
        un = abs64(num);
        ud = abs64(den);
        neg = (num < 0) != (den < 0);
        q = un / ud;
        r = un % ud;
        if (q >= 64'h1_0000) begin
            return apply_sign(64'h1_0000_0000, neg);
        end
        for (int i = 0; i < 16; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= ud) begin
                r = r - ud;
                q = q | 64'd1;
            end
        end
        return apply_sign(q, neg);
    endfunction

    // Q15.16 product, truncated toward zero and saturated.
    function automatic longint q16_product(longint a, longint b);
        longint unsigned ua, ub;
        ua = abs64(clamp32(a));
        ub = abs64(b);
        if (ub > 64'hFFFF_FFFF) begin
            ub = 64'hFFFF_FFFF;
        end
        return apply_sign((ua * ub) >> 16, (a < 0) != (b < 0));
    endfunction

    function automatic longint dot3w(wvec_t a, wvec_t b);
        return a.xc * b.xc + a.yc * b.yc + a.zc * b.zc;
    endfunction

    function automatic longint height_lookup(int unsigned code);
        return height_mem[code > TOP_CODE ? TOP_CODE : code];
    endfunction

    function automatic wvec_t unpack_vec(logic [62:0] d);
        wvec_t v;
        v.xc = longint'(signed'(d[20:0]));
        v.yc = longint'(signed'(d[41:21]));
        v.zc = longint'(signed'(d[62:42]));
        return v;
    endfunction

    // Panel coordinate along one axis, first boundary crossing and step direction.
    function automatic void axis_crossing(input wvec_t ax, input wvec_t rel, input wvec_t dir,
                                          output longint coord, output longint next,
                                          output longint delta, output int step);
        longint aa, ar, av, band, lo, hi;
        aa = dot3w(ax, ax);
        ar = dot3w(ax, rel);
        av = dot3w(ax, dir);
        next = 0;
        delta = 0;
        step = 1;
        coord = q16_quotient(ar, aa);
        if (coord < 0) begin
            return;
        end
        band = coord / 65536;
        lo = q16_quotient(band * aa - ar, av);
        hi = q16_quotient((band + 1) * aa - ar, av);
        delta = hi - lo;
        if (hi > lo) begin
            next = hi;
        end else begin
            step = -1;
            next = lo;
        end
    endfunction

    // Walk the ray across pixel columns and work out the hit it reports.
    function automatic t_out_item march_ray(t_in_item it);
        wvec_t p, v, rel;
        longint fx, fy, nx, ny, dx, dy, dzz, z, zpert, maxz, t, nt, cx, cy, w, h;
        int sx, sy;
        bit in_panel;
        int unsigned code;
        t_out_item res;
        res = '0;
        p.xc = longint'(it.ray_px);
        p.yc = longint'(it.ray_py);
        p.zc = longint'(it.ray_pz);
        v.xc = longint'(it.ray_vx);
        v.yc = longint'(it.ray_vy);
        v.zc = longint'(it.ray_vz);
        rel.xc = p.xc - vec_reg[0].xc;
        rel.yc = p.yc - vec_reg[0].yc;
        rel.zc = p.zc - vec_reg[0].zc;
        w = width_reg > PANEL_SPAN ? PANEL_SPAN : width_reg;
        h = height_reg > PANEL_SPAN ? PANEL_SPAN : height_reg;
        axis_crossing(vec_reg[1], rel, v, fx, nx, dx, sx);
        axis_crossing(vec_reg[2], rel, v, fy, ny, dy, sy);
        if (fx < 0 || fy < 0) begin
            return res;
        end
        cx = fx / 65536;
        cy = fy / 65536;
        if (cx >= w || cy >= h) begin
            return res;
        end
        dzz = dot3w(vec_reg[3], vec_reg[3]);
        z = q16_quotient(dot3w(rel, vec_reg[3]), dzz);
        zpert = q16_quotient(dot3w(v, vec_reg[3]), dzz);
        maxz = height_lookup(TOP_CODE) + longint'(SLAB_MARGIN);
        t = 0;
        code = depth_mem[cy * PANEL_SPAN + cx];
        in_panel = 1;
        while (z < maxz && in_panel && z > height_lookup(code) && (code > 0 || z > 0)) begin
            nt = nx < ny ? nx : ny;
            z = clamp32(z + q16_product(zpert, nt - t));
            if (z <= height_lookup(code)) begin
                break;
            end
            t = nt;
            if (nx < ny) begin
                nx = clamp32(nx + dx * sx);
                cx += sx;
            end else begin
                ny = clamp32(ny + dy * sy);
                cy += sy;
            end
            in_panel = cx >= 0 && cx < w && cy >= 0 && cy < h;
            code = in_panel ? depth_mem[cy * PANEL_SPAN + cx] : 0;
        end
        if (z < maxz && in_panel && code > 0) begin
            res.hit = 1'b1;
            res.hit_x = cx[7:0];
            res.hit_y = cy[7:0];
        end
        return res;
    endfunction

    // Follow the three channels on each rising edge.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                vec_reg[i] = '0;
            end
            width_reg = USED_SIZE_RESET;
            height_reg = USED_SIZE_RESET;
            hit_expect_q.delete();
            o_fail_count = 0;
            o_hits_seen = 0;
        end else begin
            // Result beat: compare with the oldest expectation.
            if (i_out_valid && !i_out_stall) begin
                if (hit_expect_q.size() == 0) begin
                    $error("result beat with no ray outstanding: hit %0d x %0d y %0d",
                           i_out_data.hit, i_out_data.hit_x, i_out_data.hit_y);
                    o_fail_count++;
                end else begin
                    want = hit_expect_q.pop_front();
                    if (i_out_data.hit) o_hits_seen++;
                    if (i_out_data.hit !== want.hit) begin
                        $error("hit expected %0d actual %0d", want.hit, i_out_data.hit);
                        o_fail_count++;
                    end
                    if (i_out_data.hit_x !== want.hit_x) begin
                        $error("hit_x expected %0d actual %0d", want.hit_x, i_out_data.hit_x);
                        o_fail_count++;
                    end
                    if (i_out_data.hit_y !== want.hit_y) begin
                        $error("hit_y expected %0d actual %0d", want.hit_y, i_out_data.hit_y);
                        o_fail_count++;
                    end
                end
            end
            // Register write.
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PANEL_ORIGIN, CFG_X_STEP_VECTOR, CFG_Y_STEP_VECTOR, CFG_HEIGHT_AXIS: begin
                        vec_reg[i_cfg_index] = unpack_vec(i_cfg_data);
                    end
                    CFG_USED_WIDTH: begin
                        width_reg = i_cfg_data[8:0];
                    end
                    CFG_USED_HEIGHT: begin
                        height_reg = i_cfg_data[8:0];
                    end
                    default: begin
                    end
                endcase
            end
            // Input beat: update the stores or predict a ray.
            if (i_in_valid && !i_in_stall) begin
                case (i_in_data.op)
                    OP_LOAD_PIXEL: begin
                        depth_mem[{i_in_data.pixel_y, i_in_data.pixel_x}] = i_in_data.depth_code;
                    end
                    OP_LOAD_TABLE: begin
                        height_mem[i_in_data.table_index] = longint'(i_in_data.table_value);
                    end
                    OP_CAST_RAY: begin
                        hit_expect_q = {hit_expect_q, march_ray(i_in_data)};
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_rays_pending = hit_expect_q.size();
    end

endmodule

// ----- sim/heightfield_pixel_ray_march_tb.sv -----
// Testbench top for the heightfield ray marcher: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module heightfield_pixel_ray_march_tb;
    import hpr_pkg::*;

    localparam int IDLE_LIMIT = 40000;
    localparam int HOLD_CYCLES = 2000;
    localparam int RAYS_PER_SETTING = 95;
    localparam logic [2:0] CFG_UNUSED_INDEX = 3'd6;
    localparam longint ONE = 65536;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_item    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [62:0] cfg_data = '0;

    int fail_count, rays_pending, hits_seen;
    int idle_cycles = 0;
    int rays_sent = 0, loads_sent = 0, settings_used = 0;
    bit calm = 0;
    bit hold_req = 0;
    bit pixel_loaded [65536];

    // Current panel geometry as the stimulus sees it.
    longint org_x, org_y, org_z, step_a, step_b, step_c;
    int     cur_w, cur_h;
    bit     aligned;

    always #6 i_clk = ~i_clk;

    heightfield_pixel_ray_march dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    heightfield_ray_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_rays_pending(rays_pending),
        .o_hits_seen   (hits_seen)
    );

    // Watchdog: cycles in which no beat moves on any channel.
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("heightfield_pixel_ray_march: mismatch");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one, none while calm.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 0;
                out_stall = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
            end else begin
                stall_left = pick_gap();
                out_stall = (stall_left > 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    // Offer one input beat after a random gap and wait until it is taken.
    task automatic offer_item(t_in_item it);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_data = it;
        do @(posedge i_clk); while (in_stall);
        if (it.op == OP_CAST_RAY) rays_sent++;
        else if (it.op != OP_CAST_RAY + 2'd1) loads_sent++;
    endtask

    task automatic write_register(logic [2:0] idx, logic [62:0] value);
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // Stop offering and wait until every ray has answered.
    task automatic drain_rays();
        @(negedge i_clk);
        in_valid = 1'b0;
        wait (rays_pending == 0);
        repeat (40) @(negedge i_clk);
    endtask

    function automatic logic [62:0] pack_vec(longint x, longint y, longint z);
        return {z[20:0], y[20:0], x[20:0]};
    endfunction

    function automatic t_in_item noise_item();
        t_in_item it;
        it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return it;
    endfunction

    task automatic load_pixel(int x, int y, logic [7:0] code);
        t_in_item it;
        it = noise_item();
        it.op = OP_LOAD_PIXEL;
        it.pixel_x = x[7:0];
        it.pixel_y = y[7:0];
        it.depth_code = code;
        pixel_loaded[{y[7:0], x[7:0]}] = 1;
        offer_item(it);
    endtask

    task automatic load_height(int idx, logic signed [31:0] value);
        t_in_item it;
        it = noise_item();
        it.op = OP_LOAD_TABLE;
        it.table_index = idx[7:0];
        it.table_value = value;
        offer_item(it);
    endtask

    function automatic logic [7:0] random_code();
        return ($urandom_range(0, 9) < 3) ? 8'd0 : 8'($urandom);
    endfunction

    // Ray with origin given relative to the panel corner, in Q15.16.
    function automatic t_in_item aimed_ray(longint rx, longint ry, longint rz,
                                           longint vx, longint vy, longint vz);
        t_in_item it;
        it = noise_item();
        it.op = OP_CAST_RAY;
        it.ray_px = 32'(org_x + rx);
        it.ray_py = 32'(org_y + ry);
        it.ray_pz = 32'(org_z + rz);
        it.ray_vx = 32'(vx);
        it.ray_vy = 32'(vy);
        it.ray_vz = 32'(vz);
        return it;
    endfunction

    // Random ray: mostly starting inside the panel and heading down.
    function automatic t_in_item make_ray();
        t_in_item it;
        longint rx, ry, rz, vx, vy, vz;
        if (!aligned || cur_w == 0 || $urandom_range(0, 9) == 0) begin
            it = noise_item();
            it.op = OP_CAST_RAY;
            return it;
        end
        rx = longint'($urandom_range(0, cur_w - 1)) * step_a + $urandom_range(0, step_a - 1);
        ry = longint'($urandom_range(0, cur_h - 1)) * step_b + $urandom_range(0, step_b - 1);
        rz = (longint'($urandom_range(0, 10 * ONE)) * step_c) >>> 16;
        vx = longint'($urandom_range(0, 4 * ONE)) - 2 * ONE;
        vy = longint'($urandom_range(0, 4 * ONE)) - 2 * ONE;
        vz = ($urandom_range(0, 7) == 0) ? longint'($urandom_range(0, ONE))
                                         : -longint'($urandom_range(0, ONE));
        return aimed_ray(rx, ry, rz, vx, vy, vz);
    endfunction

    // New panel setting; only written once the block has gone quiet.
    task automatic apply_setting(logic [8:0] w, logic [8:0] h, bit axis_aligned);
        drain_rays();
        aligned = axis_aligned;
        org_x = longint'($urandom_range(0, 8 * ONE)) - 4 * ONE;
        org_y = longint'($urandom_range(0, 8 * ONE)) - 4 * ONE;
        org_z = longint'($urandom_range(0, 4 * ONE)) - 2 * ONE;
        step_a = $urandom_range(ONE / 4, 2 * ONE);
        step_b = $urandom_range(ONE / 4, 2 * ONE);
        step_c = $urandom_range(ONE / 4, 2 * ONE);
        if (axis_aligned) begin
            write_register(CFG_PANEL_ORIGIN, pack_vec(org_x, org_y, org_z));
            write_register(CFG_X_STEP_VECTOR, pack_vec(step_a, 0, 0));
            write_register(CFG_Y_STEP_VECTOR, pack_vec(0, step_b, 0));
            write_register(CFG_HEIGHT_AXIS, pack_vec(0, 0, step_c));
        end else begin
            write_register(CFG_PANEL_ORIGIN, 63'({$urandom, $urandom}));
            write_register(CFG_X_STEP_VECTOR, 63'({$urandom, $urandom}));
            write_register(CFG_Y_STEP_VECTOR, 63'({$urandom, $urandom}));
            write_register(CFG_HEIGHT_AXIS, 63'({$urandom, $urandom}));
        end
        write_register(CFG_USED_WIDTH, {54'($urandom), w});
        write_register(CFG_USED_HEIGHT, {54'($urandom), h});
        cur_w = (w > 256) ? 256 : w;
        cur_h = (h > 256) ? 256 : h;
        settings_used++;
        // Every column a ray may read gets a depth code first.
        for (int y = 0; y < cur_h; y++)
            for (int x = 0; x < cur_w; x++)
                if (!pixel_loaded[{y[7:0], x[7:0]}]) load_pixel(x, y, random_code());
    endtask

    // Mostly rays, mixed with reloads, stray loads and unused ops.
    task automatic random_traffic(int n);
        t_in_item it;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 75 || (r < 85 && cur_w == 0)) begin
                offer_item(make_ray());
            end else if (r < 85) begin
                load_pixel($urandom_range(0, cur_w - 1), $urandom_range(0, cur_h - 1),
                           random_code());
            end else if (r < 92) begin
                load_pixel($urandom_range(0, 255), $urandom_range(0, 255), 8'($urandom));
            end else if (r < 96) begin
                load_height($urandom_range(0, 254), $urandom_range(0, 6 * ONE));
            end else begin
                it = noise_item();
                it.op = OP_CAST_RAY + 2'd1;
                offer_item(it);
            end
        end
    endtask

    initial begin
        t_in_item it;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Small panel with unit axes for the directed rays.
        aligned = 1;
        org_x = -3 * ONE;
        org_y = -2 * ONE;
        org_z = ONE;
        step_a = ONE;
        step_b = ONE;
        step_c = ONE;
        write_register(CFG_PANEL_ORIGIN, pack_vec(org_x, org_y, org_z));
        write_register(CFG_X_STEP_VECTOR, pack_vec(ONE, 0, 0));
        write_register(CFG_Y_STEP_VECTOR, pack_vec(0, ONE, 0));
        write_register(CFG_HEIGHT_AXIS, pack_vec(0, 0, ONE));
        write_register(CFG_USED_WIDTH, 63'd6);
        write_register(CFG_USED_HEIGHT, 63'd5);
        write_register(CFG_UNUSED_INDEX, 63'({$urandom, $urandom}));
        cur_w = 6;
        cur_h = 5;
        settings_used = 1;

        // Height table: the top code sets the slab, codes 1 and 2 sit at the extremes.
        for (int k = 0; k < 256; k++) begin
            if (k == 255) load_height(k, 8 * ONE);
            else if (k == 1) load_height(k, S32_MIN);
            else if (k == 2) load_height(k, S32_MAX);
            else load_height(k, $urandom_range(0, 6 * ONE));
        end
        for (int y = 0; y < 5; y++)
            for (int x = 0; x < 6; x++)
                load_pixel(x, y, random_code());
        load_pixel(0, 0, 8'd2);
        load_pixel(5, 4, 8'd1);

        // Directed rays: corners, edges of the panel, zero and extreme directions.
        offer_item(aimed_ray(0, 0, 7 * ONE + ONE / 2, ONE, ONE, -ONE / 2));
        offer_item(aimed_ray(386662, 321126, 6 * ONE, -ONE, -ONE / 2, -ONE / 4));
        offer_item(aimed_ray(-1, ONE, 5 * ONE, ONE, 0, -ONE / 4));
        offer_item(aimed_ray(6 * ONE, ONE, 5 * ONE, -ONE, 0, -ONE / 4));
        offer_item(aimed_ray(2 * ONE + ONE / 2, 2 * ONE + ONE / 2, 5 * ONE, 0, 0, 0));
        offer_item(aimed_ray(ONE + ONE / 2, 3 * ONE + ONE / 2, 5 * ONE, 3 * ONE / 4, -ONE / 3, 0));
        offer_item(aimed_ray(3 * ONE + ONE / 5, ONE + ONE / 10, 7 * ONE, 0, 0, -ONE));
        offer_item(aimed_ray(2 * ONE, 2 * ONE, 9 * ONE, ONE / 2, ONE / 2, -ONE / 10));
        offer_item(aimed_ray(4 * ONE + ONE / 2, ONE / 2, -ONE, ONE, 0, -ONE / 10));
        offer_item(aimed_ray(ONE, ONE, 3 * ONE, S32_MAX, S32_MIN, S32_MIN));
        it = aimed_ray(0, 0, 0, S32_MIN, S32_MAX, S32_MAX);
        it.ray_px = S32_MAX;
        it.ray_py = S32_MIN;
        it.ray_pz = S32_MAX;
        offer_item(it);
        it = noise_item();
        it.op = OP_CAST_RAY + 2'd1;
        offer_item(it);
        random_traffic(RAYS_PER_SETTING);

        // One wide row; the width above the panel limit is clipped.
        apply_setting(9'd511, 9'd1, 1);
        random_traffic(RAYS_PER_SETTING / 2);
        drain_rays();
        random_traffic(RAYS_PER_SETTING / 2);

        // No columns in use at full height, arbitrary vectors.
        apply_setting(9'd0, 9'd256, 0);
        random_traffic(RAYS_PER_SETTING);

        // Mid-size panel; the receiver holds off while rays keep coming.
        apply_setting(9'd12, 9'd9, 1);
        hold_req = 1;
        random_traffic(RAYS_PER_SETTING);

        // Tiny panel with arbitrary vectors; the first half runs with no idling on either side.
        apply_setting(9'd3, 9'd2, 0);
        calm = 1;
        random_traffic(RAYS_PER_SETTING / 2);
        calm = 0;
        random_traffic(RAYS_PER_SETTING / 2);

        @(negedge i_clk);
        in_valid = 1'b0;
        wait (rays_pending == 0);
        repeat (3000) @(negedge i_clk);

        $display("Covered %0d rays (%0d hits) and %0d loads over %0d panel settings.",
                 rays_sent, hits_seen, loads_sent, settings_used);
        $display("Settings included zero, one, full and clipped panel sizes.");
        if (fail_count == 0) begin
            $display("heightfield_pixel_ray_march: match");
        end else begin
            $display("heightfield_pixel_ray_march: mismatch");
        end
        $finish;
    end

endmodule
